[hw/rtl/jsu_pkg.sv]
// shared types and constants for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

  // register and counter widths fixed by the field definitions
  localparam int unsigned LEN_W     = 19;
  localparam int unsigned MAX_BYTES = 4;

  // result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  // code point ranges
  localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] CP_MAX_1B     = 21'h7F;
  localparam logic [20:0] CP_MAX_2B     = 21'h7FF;
  localparam logic [20:0] CP_MAX_3B     = 21'hFFFF;

  // utf-8 lead and continuation marks
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_STR     = 4'd1,
    M_ESC     = 4'd2,
    M_HEX0    = 4'd3,
    M_HEX1    = 4'd4,
    M_HEX2    = 4'd5,
    M_HEX3    = 4'd6,
    M_NEED_BS = 4'd7,
    M_NEED_U  = 4'd8,
    M_LOW0    = 4'd9,
    M_LOW1    = 4'd10,
    M_LOW2    = 4'd11,
    M_LOW3    = 4'd12
  } mode_t;

  // results caused by one input byte: count of 0 means none
  typedef struct packed {
    logic [2:0]                count;
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                status;
  } res_t;

endpackage

[hw/rtl/json_string_unescaper.sv]
// top level of the json string unescaper: input register, decode, result drain
`timescale 1ns / 1ps

// channel  | dir | tdata            | tuser      | tlast
// s_axis   | in  | in_byte [7:0]    | -          | end_of_data
// m_axis   | out | out_byte [7:0]   | status[1:0]| last (final result of one byte)
// cfg      | in  | max_length[18:0] written when cfg_we is high
//
// one raw byte per cycle while m_axis takes results; while a \u escape that yields a 2, 3 or 4 byte
// utf-8 sequence drains, the next byte with a result waits until the last byte of
// that sequence is taken on m_axis
// each byte passes the input register, then is decoded into the result register,
// from which its first result is presented
// bytes that make no result (backslash, hex digits) pass without using the drain
// rst is synchronous; it empties both registers and returns to awaiting a quote
// a stall on m_axis backs up into s_axis tready within the same cycle

module json_string_unescaper
  import jsu_pkg::*;
#(
  parameter int unsigned LENGTH_LIMIT = 262144
) (
  input  logic             clk,
  input  logic             rst,
  // config
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,    // max_length
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] in_byte
  input  logic             s_axis_tlast,  // end_of_data
  // output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]       m_axis_tuser,  // [1:0] status
  output logic             m_axis_tlast   // last
);

  // limit clipped to what the register can hold
  localparam logic [LEN_W-1:0] LIMIT_CLIP =
    (LENGTH_LIMIT > ((1 << LEN_W) - 1)) ? {LEN_W{1'b1}} : LEN_W'(LENGTH_LIMIT);

  logic [LEN_W-1:0] max_length;
  logic [LEN_W-1:0] limit;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eod;

  res_t res;
  logic free;
  logic advance;
  logic s_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= LIMIT_CLIP;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  assign limit = (max_length < LIMIT_CLIP) ? max_length : LIMIT_CLIP;

  // the held byte moves on when its results fit in the result register,
  // or at once when it makes none
  assign advance       = in_valid && (free || (res.count == 3'd0));
  assign s_axis_tready = !in_valid || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_byte <= s_axis_tdata;
      in_eod  <= s_axis_tlast;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .eod     (in_eod),
    .limit   (limit),
    .res     (res)
  );

  jsu_drain u_drain (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && (res.count != 3'd0)),
    .load_res      (res),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hw/rtl/jsu_decode.sv]
// parser state and single-pass decode of one raw byte into up to four results
`timescale 1ns / 1ps

module jsu_decode
  import jsu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             eod,
  input  logic [LEN_W-1:0] limit,
  output res_t             res
);

  mode_t            mode, mode_next;
  logic [15:0]      acc, acc_next;
  logic [9:0]       hs, hs_next;
  logic [LEN_W-1:0] emitted, emitted_next;

  logic [4:0]  hx;
  logic [15:0] acc_shift;
  logic [20:0] pair_cp;
  logic [1:0]  kind;
  res_t        raw;
  logic        over;
  logic        fail;

  // {valid, value} of a hex digit, either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic res_t utf8_encode(input logic [20:0] cp);
    res_t r;
    r = '0;
    r.status = ST_DATA;
    if (cp <= CP_MAX_1B) begin
      r.count    = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= CP_MAX_2B) begin
      r.count    = 3'd2;
      r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp <= CP_MAX_3B) begin
      r.count    = 3'd3;
      r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
      r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      r.count    = 3'd4;
      r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
      r.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
      r.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

  assign hx        = hex_digit(in_byte);
  assign acc_shift = {acc[11:0], hx[3:0]};
  assign pair_cp   = SUPP_BASE + {1'b0, hs, acc_shift[9:0]};

  // result of this byte before length and end-of-data checks
  always_comb begin
    kind = ST_DATA;
    raw  = '0;
    case (mode)
      M_STR: begin
        if (in_byte == CH_QUOTE) begin
          kind = ST_DONE;
        end else if (in_byte < CH_SPACE) begin
          kind = ST_ERROR;
        end else if (in_byte != CH_BSLASH) begin
          raw.count    = 3'd1;
          raw.bytes[0] = in_byte;
        end
      end
      M_ESC: begin
        raw.count = 3'd1;
        case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: raw.bytes[0] = in_byte;
          CH_B:    raw.bytes[0] = CTL_BS;
          CH_F:    raw.bytes[0] = CTL_FF;
          CH_N:    raw.bytes[0] = CTL_LF;
          CH_R:    raw.bytes[0] = CTL_CR;
          CH_T:    raw.bytes[0] = CTL_TAB;
          CH_U:    raw.count    = 3'd0;
          default: begin
            raw.count = 3'd0;
            kind      = ST_ERROR;
          end
        endcase
      end
      M_HEX0, M_HEX1, M_HEX2, M_LOW0, M_LOW1, M_LOW2: begin
        if (!hx[4]) begin
          kind = ST_ERROR;
        end
      end
      M_HEX3: begin
        if (!hx[4]) begin
          kind = ST_ERROR;
        end else if (acc_shift >= SURR_LO_FIRST && acc_shift <= SURR_LO_LAST) begin
          kind = ST_ERROR;
        end else if (!(acc_shift >= SURR_HI_FIRST && acc_shift <= SURR_HI_LAST)) begin
          raw = utf8_encode({5'b00000, acc_shift});
        end
      end
      M_LOW3: begin
        if (!hx[4] || acc_shift < SURR_LO_FIRST || acc_shift > SURR_LO_LAST) begin
          kind = ST_ERROR;
        end else begin
          raw = utf8_encode(pair_cp);
        end
      end
      M_NEED_BS: begin
        if (in_byte != CH_BSLASH) begin
          kind = ST_ERROR;
        end
      end
      M_NEED_U: begin
        if (in_byte != CH_U) begin
          kind = ST_ERROR;
        end
      end
      default: begin
        if (in_byte != CH_QUOTE) begin
          kind = ST_ERROR;
        end
      end
    endcase
  end

  // length limit and truncated input override a data result
  assign over = (kind == ST_DATA) && (raw.count != 3'd0) &&
                (({1'b0, emitted} + {{(LEN_W-2){1'b0}}, raw.count}) > {1'b0, limit});
  assign fail = (kind == ST_ERROR) || over || ((kind == ST_DATA) && eod);

  always_comb begin
    res = '0;
    if (fail) begin
      res.count  = 3'd1;
      res.status = ST_ERROR;
    end else if (kind == ST_DONE) begin
      res.count  = 3'd1;
      res.status = ST_DONE;
    end else begin
      res = raw;
    end
  end

  // next state
  always_comb begin
    mode_next    = mode;
    acc_next     = acc;
    hs_next      = hs;
    emitted_next = emitted;
    case (mode)
      M_STR: begin
        if (in_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end
      end
      M_ESC: begin
        if (in_byte == CH_U) begin
          mode_next = M_HEX0;
          acc_next  = '0;
        end else begin
          mode_next = M_STR;
        end
      end
      M_HEX0, M_HEX1, M_HEX2, M_LOW0, M_LOW1, M_LOW2: begin
        acc_next  = acc_shift;
        mode_next = mode_t'(mode + 4'd1);
      end
      M_HEX3: begin
        acc_next = acc_shift;
        if (acc_shift >= SURR_HI_FIRST && acc_shift <= SURR_HI_LAST) begin
          hs_next   = acc_shift[9:0];
          mode_next = M_NEED_BS;
        end else begin
          mode_next = M_STR;
        end
      end
      M_LOW3: begin
        acc_next  = acc_shift;
        mode_next = M_STR;
      end
      M_NEED_BS: mode_next = M_NEED_U;
      M_NEED_U: begin
        mode_next = M_LOW0;
        acc_next  = '0;
      end
      default: begin
        if (in_byte == CH_QUOTE) begin
          mode_next    = M_STR;
          emitted_next = '0;
        end
      end
    endcase
    if (res.status != ST_DATA) begin
      mode_next = M_IDLE;
    end else begin
      emitted_next = emitted_next + {{(LEN_W-3){1'b0}}, res.count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      acc     <= '0;
      hs      <= '0;
      emitted <= '0;
    end else if (step) begin
      mode    <= mode_next;
      acc     <= acc_next;
      hs      <= hs_next;
      emitted <= emitted_next;
    end
  end

endmodule

[hw/rtl/jsu_drain.sv]
// result register that hands out the bytes of one decoded item one per cycle while m_axis_tready is high
`timescale 1ns / 1ps

module jsu_drain
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_t       load_res,
  output logic       free,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic [1:0] m_axis_tuser,
  output logic       m_axis_tlast
);

  res_t       res;
  logic       valid;
  logic [1:0] idx;
  logic       take;
  logic       at_end;

  assign at_end        = ({1'b0, idx} == (res.count - 3'd1));
  assign take          = valid && m_axis_tready;
  assign free          = !valid || (take && at_end);
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = res.bytes[idx];
  assign m_axis_tuser  = res.status;
  assign m_axis_tlast  = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take) begin
      if (at_end) begin
        valid <= 1'b0;
        idx   <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (res.count != 3'd0) && ({1'b0, idx} < res.count))
    else $error("drain index past item length");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    valid && (res.status != ST_DATA) |-> (res.count == 3'd1) && (res.bytes[0] == 8'h00))
    else $error("done or error result is not a single zero byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !valid || (take && at_end))
    else $error("result register loaded before drained");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    valid && take && !at_end && !load |=> valid && (idx == $past(idx) + 2'd1))
    else $error("drain index did not advance");

endmodule

[sim/json_string_unescaper_test.sv]
// self-checking testbench for the json string unescaper: directed strings, then random strings
`timescale 1ns / 1ps

module json_string_unescaper_test
  import jsu_pkg::*;
();

  localparam int unsigned LEN_LIMIT = 262144;
  // longest run of cycles with no transaction on either side before giving up; a
  // correct run stays under it even with the receiver stalling 48%
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [LEN_W-1:0] MAX_LEN_TOP = '1;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b1;
  logic [7:0]       m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;

  // decoder state kept by the testbench
  mode_t            p_mode = M_IDLE;
  logic [15:0]      p_hex = '0;
  logic [9:0]       p_high = '0;
  logic [LEN_W-1:0] p_count = '0;
  logic [LEN_W-1:0] p_max_len = LEN_W'(LEN_LIMIT);

  result_t decoded_queue[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int done_seen = 0;
  int errors_seen = 0;
  int failures = 0;
  int quiet_cycles = 0;

  logic [7:0] esc_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

  json_string_unescaper #(
    .LENGTH_LIMIT(LEN_LIMIT)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // hex digit in random case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return (($urandom_range(1) != 0) ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
  endfunction

  // value in [lo, hi] that lands on either bound now and then
  function automatic logic [15:0] skewed_pick(input int lo, input int hi);
    case ($urandom_range(7))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [7:0] random_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h7E, CH_SPACE)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (hex_value(c) >= 0);
    return c;
  endfunction

  // work out what one accepted byte produces and queue it
  task automatic unescape_byte(input logic [7:0] b, input logic eod);
    logic [7:0] enc[MAX_BYTES];
    logic [1:0] kind;
    logic       have_cp;
    result_t    r;
    int         n, d, cp, limit;
    n = 0;
    cp = 0;
    have_cp = 1'b0;
    kind = ST_DATA;
    limit = (p_max_len > LEN_LIMIT) ? LEN_LIMIT : int'(p_max_len);
    case (p_mode)
      M_STR: begin
        if (b == CH_QUOTE) kind = ST_DONE;
        else if (b < CH_SPACE) kind = ST_ERROR;
        else if (b == CH_BSLASH) p_mode = M_ESC;
        else begin
          enc[0] = b;
          n = 1;
        end
      end
      M_ESC: begin
        p_mode = M_STR;
        n = 1;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: enc[0] = b;
          CH_B: enc[0] = CTL_BS;
          CH_F: enc[0] = CTL_FF;
          CH_N: enc[0] = CTL_LF;
          CH_R: enc[0] = CTL_CR;
          CH_T: enc[0] = CTL_TAB;
          CH_U: begin
            p_mode = M_HEX0;
            p_hex = '0;
            n = 0;
          end
          default: begin
            kind = ST_ERROR;
            n = 0;
          end
        endcase
      end
      M_HEX0, M_HEX1, M_HEX2, M_HEX3, M_LOW0, M_LOW1, M_LOW2, M_LOW3: begin
        d = hex_value(b);
        if (d < 0) kind = ST_ERROR;
        else begin
          p_hex = {p_hex[11:0], 4'(d)};
          if (p_mode == M_HEX3) begin
            if (p_hex >= SURR_HI_FIRST && p_hex <= SURR_HI_LAST) begin
              // the low ten bits are the offset from the first high surrogate
              p_high = p_hex[9:0];
              p_mode = M_NEED_BS;
            end else if (p_hex >= SURR_LO_FIRST && p_hex <= SURR_LO_LAST) begin
              kind = ST_ERROR;
            end else begin
              cp = int'(p_hex);
              have_cp = 1'b1;
              p_mode = M_STR;
            end
          end else if (p_mode == M_LOW3) begin
            if (p_hex < SURR_LO_FIRST || p_hex > SURR_LO_LAST) kind = ST_ERROR;
            else begin
              cp = int'(SUPP_BASE) + int'({p_high, p_hex[9:0]});
              have_cp = 1'b1;
              p_mode = M_STR;
            end
          end else begin
            p_mode = mode_t'(p_mode + 4'd1);
          end
        end
      end
      M_NEED_BS: begin
        if (b == CH_BSLASH) p_mode = M_NEED_U;
        else kind = ST_ERROR;
      end
      M_NEED_U: begin
        if (b == CH_U) begin
          p_mode = M_LOW0;
          p_hex = '0;
        end else begin
          kind = ST_ERROR;
        end
      end
      default: begin
        if (b == CH_QUOTE) begin
          p_mode = M_STR;
          p_count = '0;
        end else begin
          kind = ST_ERROR;
        end
      end
    endcase

    if (have_cp) begin
      if (cp <= int'(CP_MAX_1B)) begin
        enc[0] = cp[7:0];
        n = 1;
      end else if (cp <= int'(CP_MAX_2B)) begin
        enc[0] = UTF8_LEAD2 | {3'b0, cp[10:6]};
        enc[1] = UTF8_CONT | {2'b0, cp[5:0]};
        n = 2;
      end else if (cp <= int'(CP_MAX_3B)) begin
        enc[0] = UTF8_LEAD3 | {4'b0, cp[15:12]};
        enc[1] = UTF8_CONT | {2'b0, cp[11:6]};
        enc[2] = UTF8_CONT | {2'b0, cp[5:0]};
        n = 3;
      end else begin
        enc[0] = UTF8_LEAD4 | {5'b0, cp[20:18]};
        enc[1] = UTF8_CONT | {2'b0, cp[17:12]};
        enc[2] = UTF8_CONT | {2'b0, cp[11:6]};
        enc[3] = UTF8_CONT | {2'b0, cp[5:0]};
        n = 4;
      end
    end

    // length overflow and early end of data turn the whole byte into one error
    if (kind == ST_DATA && n > 0 && int'(p_count) + n > limit) kind = ST_ERROR;
    if (kind == ST_DATA && eod) kind = ST_ERROR;

    if (kind != ST_DATA) begin
      r.data = 8'h00;
      r.status = kind;
      r.last = 1'b1;
      decoded_queue = {decoded_queue, r};
      p_mode = M_IDLE;
    end else begin
      for (int i = 0; i < n; i++) begin
        r.data = enc[i];
        r.status = ST_DATA;
        r.last = (i == n - 1);
        decoded_queue = {decoded_queue, r};
      end
      p_count = p_count + LEN_W'(n);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    failures++;
  endtask

  // one input transaction; entered and left at a falling edge with tvalid low
  task automatic send_byte(input logic [7:0] b, input logic eod);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    s_axis_tdata = b;
    s_axis_tlast = eod;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    unescape_byte(b, eod);
    bytes_sent++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_u_escape(input logic [15:0] v);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_U, 1'b0);
    send_byte(hex_char(v[15:12]), 1'b0);
    send_byte(hex_char(v[11:8]), 1'b0);
    send_byte(hex_char(v[7:4]), 1'b0);
    send_byte(hex_char(v[3:0]), 1'b0);
  endtask

  task automatic send_good_token();
    logic [15:0] v;
    case ($urandom_range(6))
      0: send_byte(random_plain(), 1'b0);
      1: send_byte(8'($urandom_range(8'hFF, 8'h80)), 1'b0);
      2: begin
        send_byte(CH_BSLASH, 1'b0);
        send_byte(esc_letters[$urandom_range(7)], 1'b0);
      end
      3: send_u_escape(skewed_pick(0, int'(CP_MAX_1B)));
      4: send_u_escape(skewed_pick(int'(CP_MAX_1B) + 1, int'(CP_MAX_2B)));
      5: begin
        do v = skewed_pick(int'(CP_MAX_2B) + 1, int'(CP_MAX_3B));
        while (v >= SURR_HI_FIRST && v <= SURR_LO_LAST);
        send_u_escape(v);
      end
      default: begin
        send_u_escape(skewed_pick(int'(SURR_HI_FIRST), int'(SURR_HI_LAST)));
        send_u_escape(skewed_pick(int'(SURR_LO_FIRST), int'(SURR_LO_LAST)));
      end
    endcase
  endtask

  // a malformed ending; entered inside a string, every choice leaves the decoder idle after its error
  task automatic send_broken_tail();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(7))
      0: send_byte(8'($urandom_range(CH_SPACE - 1)), 1'b0);
      1: begin
        send_byte(CH_BSLASH, 1'b0);
        do c = 8'($urandom_range(255));
        while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        send_byte(c, 1'b0);
      end
      2: begin
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15))), 1'b0);
        send_byte(random_non_hex(), 1'b0);
      end
      3: send_u_escape(skewed_pick(int'(SURR_LO_FIRST), int'(SURR_LO_LAST)));
      4: begin
        // high surrogate left without a proper low half
        send_u_escape(skewed_pick(int'(SURR_HI_FIRST), int'(SURR_HI_LAST)));
        case ($urandom_range(2))
          0: begin
            do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
            send_byte(c, 1'b0);
          end
          1: begin
            send_byte(CH_BSLASH, 1'b0);
            do c = 8'($urandom_range(255)); while (c == CH_U);
            send_byte(c, 1'b0);
          end
          default: begin
            do v = 16'($urandom_range(16'hFFFF));
            while (v >= SURR_LO_FIRST && v <= SURR_LO_LAST);
            send_u_escape(v);
          end
        endcase
      end
      5: send_byte(random_plain(), 1'b1);
      6: begin
        // stray byte while waiting for an opening quote
        send_byte(CH_QUOTE, 1'b0);
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
        send_byte(c, 1'($urandom_range(1)));
      end
      default: begin
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b1);
      end
    endcase
  endtask

  // mostly well-formed strings with random content; some end broken
  task automatic send_random_string(input int break_pct, input int max_tokens);
    int tokens;
    tokens = $urandom_range(max_tokens);
    send_byte(CH_QUOTE, 1'b0);
    for (int i = 0; i < tokens; i++) begin
      if ($urandom_range(99) < break_pct) begin
        send_broken_tail();
        return;
      end
      send_good_token();
    end
    send_byte(CH_QUOTE, 1'($urandom_range(7) == 0));
  endtask

  task automatic send_random_bytes(input int count, input int break_pct, input int max_tokens);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_string(break_pct, max_tokens);
  endtask

  // let every expected result come out, then give the pipeline time to settle
  task automatic wait_drained();
    while (decoded_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [LEN_W-1:0] v);
    wait_drained();
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(posedge clk);
    p_max_len = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_plain_and_controls();
    send_byte("x", 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_simple_escapes();
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_T, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_SLASH, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte("z", 1'b0);
  endtask

  task automatic test_surrogates();
    send_byte(CH_QUOTE, 1'b0);
    send_u_escape(16'hD83D);
    send_u_escape(16'hDE00);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_u_escape(SURR_LO_FIRST);
  endtask

  task automatic test_end_of_data();
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_QUOTE, 1'b1);
    send_byte(CH_QUOTE, 1'b1);
  endtask

  task automatic test_zero_length_limit();
    write_max_length('0);
    gap_pct = 0;
    stall_pct = 0;
    send_random_bytes(40, 10, 3);
  endtask

  task automatic test_small_length_limit();
    write_max_length(LEN_W'(5));
    gap_pct = 48;
    stall_pct = 0;
    send_random_bytes(110, 12, 5);
  endtask

  task automatic test_default_limit();
    write_max_length(LEN_W'(LEN_LIMIT));
    gap_pct = 0;
    stall_pct = 48;
    send_random_bytes(110, 12, 8);
  endtask

  task automatic test_random_limits();
    gap_pct = 21;
    stall_pct = 21;
    write_max_length(MAX_LEN_TOP);
    send_random_bytes(30, 12, 8);
    repeat (3) begin
      write_max_length(LEN_W'($urandom_range(40, 1)));
      send_random_bytes(30, 12, 8);
    end
  endtask

  // receiver side: tready changes only at the falling edge
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // compare every output transaction against the oldest expected result
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (decoded_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result data %02h status %0d last %0b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = decoded_queue.pop_front();
        if (want.status == ST_DONE) done_seen++;
        if (want.status == ST_ERROR) errors_seen++;
        if (m_axis_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, wanted %02h", m_axis_tdata, want.data));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", m_axis_tuser, want.status));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", m_axis_tlast, want.last));
      end
    end
  end

  // watchdog: too long without a transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results pending",
               quiet_cycles, decoded_queue.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed checks run on the reset value of max_length
    test_plain_and_controls();
    test_simple_escapes();
    test_surrogates();
    test_end_of_data();

    test_zero_length_limit();
    test_small_length_limit();
    test_default_limit();
    test_random_limits();

    wait_drained();
    repeat (8) @(negedge clk);

    $display("covered %0d input bytes and %0d results: %0d strings closed, %0d errors",
             bytes_sent, results_seen, done_seen, errors_seen);
    $display("max_length set from 0 to %0d, with sender gaps and receiver stalls",
             MAX_LEN_TOP);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
